[sv/bop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_pkg
// Shared types, constants and fixed-point helpers for the binomial pricer.
// ----------------------------------------------------------------------------
package bop_pkg;

    localparam int NUM_STEPS_W = 9;
    localparam int PRICE_W     = 32;
    localparam int FACTOR_W    = 32;
    localparam int FRAC_W      = 31;

    localparam logic [NUM_STEPS_W-1:0] NUM_STEPS_RST = 9'd256;
    localparam logic [FRAC_W-1:0]      ONE_Q30       = 31'h4000_0000;
    localparam logic [63:0]            HALF_Q30      = 64'h0000_0000_2000_0000;

    // Controller to datapath strobes
    typedef struct packed {
        logic load;
        logic tbl_step;
        logic tr_mul;
        logic tr_wr;
        logic lv_load;
        logic nd_m1;
        logic nd_m2;
        logic nd_m3;
        logic nd_wr;
    } bop_cmd_t;

    // (x * f + 0.5) >> 30, saturated to 32 bits
    function automatic logic [PRICE_W-1:0] mul_q30(input logic [PRICE_W-1:0] x,
                                                   input logic [FACTOR_W-1:0] f);
        logic [63:0] prod;
        logic [33:0] r;
        prod = 64'(x) * 64'(f) + HALF_Q30;
        r    = prod[63:30];
        return (r[33:32] != 2'b00) ? {PRICE_W{1'b1}} : r[31:0];
    endfunction

    function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] s,
                                                  input logic [PRICE_W-1:0] k,
                                                  input logic put);
        logic [PRICE_W-1:0] r;
        r = '0;
        if (put) begin
            if (k > s) r = k - s;
        end else begin
            if (s > k) r = s - k;
        end
        return r;
    endfunction

endpackage

[sv/bop_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/bop_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_ctrl
// Sequencer: table build, terminal row, backward induction, result hand-off.
// ----------------------------------------------------------------------------
module bop_ctrl #(
    parameter int MAX_STEPS = 256,
    parameter int AW        = $clog2(MAX_STEPS + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [bop_pkg::NUM_STEPS_W-1:0]  num_steps,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             out_free,
    output logic                             out_load,
    output bop_pkg::bop_cmd_t                cmd,
    output logic [AW-1:0]                    su_raddr,
    output logic [AW-1:0]                    dp_raddr,
    output logic [AW-1:0]                    val_raddr,
    output logic [AW-1:0]                    wr_addr
);
    import bop_pkg::*;

    localparam int NW = (AW > NUM_STEPS_W) ? AW : NUM_STEPS_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_TBL      = 4'd1;
    localparam logic [3:0] ST_TR_RD    = 4'd2;
    localparam logic [3:0] ST_TR_MUL   = 4'd3;
    localparam logic [3:0] ST_TR_WR    = 4'd4;
    localparam logic [3:0] ST_LV_PRIME = 4'd5;
    localparam logic [3:0] ST_LV_LOAD  = 4'd6;
    localparam logic [3:0] ST_ND_RD    = 4'd7;
    localparam logic [3:0] ST_ND_M1    = 4'd8;
    localparam logic [3:0] ST_ND_M2    = 4'd9;
    localparam logic [3:0] ST_ND_M3    = 4'd10;
    localparam logic [3:0] ST_ND_WR    = 4'd11;
    localparam logic [3:0] ST_OUT      = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] step_reg, step_next;
    logic [NW-1:0] num_ext;
    logic [AW-1:0] n_clamp;

    always_comb begin
        num_ext = NW'(num_steps);
        if (num_ext == '0) begin
            n_clamp = AW'(1);
        end else if (num_ext > NW'(MAX_STEPS)) begin
            n_clamp = AW'(MAX_STEPS);
        end else begin
            n_clamp = num_ext[AW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    n_next     = n_clamp;
                    i_next     = AW'(1);
                    state_next = ST_TBL;
                end
            end
            ST_TBL: begin
                if (i_reg == n_reg) begin
                    i_next     = '0;
                    state_next = ST_TR_RD;
                end else begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_TR_RD:  state_next = ST_TR_MUL;
            ST_TR_MUL: state_next = ST_TR_WR;
            ST_TR_WR: begin
                if (i_reg == n_reg) begin
                    step_next  = n_reg - AW'(1);
                    i_next     = '0;
                    state_next = ST_LV_PRIME;
                end else begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_TR_RD;
                end
            end
            ST_LV_PRIME: state_next = ST_LV_LOAD;
            ST_LV_LOAD:  state_next = ST_ND_RD;
            ST_ND_RD:    state_next = ST_ND_M1;
            ST_ND_M1:    state_next = ST_ND_M2;
            ST_ND_M2:    state_next = ST_ND_M3;
            ST_ND_M3:    state_next = ST_ND_WR;
            ST_ND_WR: begin
                if (i_reg == step_reg) begin
                    if (step_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        step_next  = step_reg - AW'(1);
                        i_next     = '0;
                        state_next = ST_LV_PRIME;
                    end
                end else begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_ND_RD;
                end
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.tbl_step = (state_reg == ST_TBL);
        cmd.tr_mul   = (state_reg == ST_TR_MUL);
        cmd.tr_wr    = (state_reg == ST_TR_WR);
        cmd.lv_load  = (state_reg == ST_LV_LOAD);
        cmd.nd_m1    = (state_reg == ST_ND_M1);
        cmd.nd_m2    = (state_reg == ST_ND_M2);
        cmd.nd_m3    = (state_reg == ST_ND_M3);
        cmd.nd_wr    = (state_reg == ST_ND_WR);
    end

    // terminal row reads S*u^(n-i); interior nodes read S*u^(step-i)
    assign su_raddr  = (state_reg == ST_TR_RD) ? (n_reg - i_reg) : (step_reg - i_reg);
    assign dp_raddr  = i_reg;
    assign val_raddr = (state_reg == ST_LV_PRIME) ? '0 : (i_reg + AW'(1));
    assign wr_addr   = (state_reg == ST_IDLE) ? '0 : i_reg;

endmodule

[sv/bop_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_dp
// Datapath: power tables, node value store, mix / discount / exercise logic.
// ----------------------------------------------------------------------------
module bop_dp #(
    parameter int MAX_STEPS = 256,
    parameter int AW        = $clog2(MAX_STEPS + 1)
) (
    input  logic                          aclk,
    input  bop_pkg::bop_cmd_t             cmd,
    input  logic [AW-1:0]                 su_raddr,
    input  logic [AW-1:0]                 dp_raddr,
    input  logic [AW-1:0]                 val_raddr,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [bop_pkg::PRICE_W-1:0]   spot,
    input  logic [bop_pkg::PRICE_W-1:0]   strike,
    input  logic                          is_put,
    input  logic                          american,
    input  logic [bop_pkg::FACTOR_W-1:0]  up_factor,
    input  logic [bop_pkg::FRAC_W-1:0]    down_factor,
    input  logic [bop_pkg::FRAC_W-1:0]    up_prob,
    input  logic [bop_pkg::FRAC_W-1:0]    discount,
    output logic [bop_pkg::PRICE_W-1:0]   result
);
    import bop_pkg::*;

    localparam int DEPTH = MAX_STEPS + 1;

    logic [PRICE_W-1:0]  k_reg;
    logic                put_reg, amer_reg;
    logic [FACTOR_W-1:0] u_reg;
    logic [FRAC_W-1:0]   d_reg, df_reg, p_reg, q_reg;
    logic [PRICE_W-1:0]  su_run_reg, dp_run_reg;
    logic [PRICE_W-1:0]  spot_reg, vup_reg, vdn_reg, mix_reg, cont_reg, res_reg;
    logic [62:0]         prod_u_reg, prod_d_reg;

    logic [PRICE_W-1:0]  su_rdata, dp_rdata, val_rdata;
    logic [PRICE_W-1:0]  su_mul, dp_mul;
    logic                tbl_we, val_we;
    logic [PRICE_W-1:0]  su_wdata, dp_wdata, val_wdata;
    logic [FRAC_W-1:0]   p_clamp;
    logic [63:0]         mix_sum;
    logic [PRICE_W-1:0]  ex_val, v_final;

    assign p_clamp = (up_prob > ONE_Q30) ? ONE_Q30 : up_prob;
    assign su_mul  = mul_q30(su_run_reg, u_reg);
    assign dp_mul  = mul_q30(dp_run_reg, FACTOR_W'(d_reg));

    assign tbl_we   = cmd.load || cmd.tbl_step;
    assign su_wdata = cmd.load ? spot : su_mul;
    assign dp_wdata = cmd.load ? PRICE_W'(ONE_Q30) : dp_mul;

    assign ex_val  = payoff(spot_reg, k_reg, put_reg);
    assign v_final = (amer_reg && (ex_val > cont_reg)) ? ex_val : cont_reg;

    assign val_we    = cmd.tr_wr || cmd.nd_wr;
    assign val_wdata = cmd.tr_wr ? ex_val : v_final;

    assign mix_sum = 64'(prod_u_reg) + 64'(prod_d_reg) + HALF_Q30;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            k_reg      <= strike;
            put_reg    <= is_put;
            amer_reg   <= american;
            u_reg      <= up_factor;
            d_reg      <= down_factor;
            df_reg     <= discount;
            p_reg      <= p_clamp;
            q_reg      <= ONE_Q30 - p_clamp;
            su_run_reg <= spot;
            dp_run_reg <= PRICE_W'(ONE_Q30);
        end
        if (cmd.tbl_step) begin
            su_run_reg <= su_mul;
            dp_run_reg <= dp_mul;
        end
        if (cmd.tr_mul || cmd.nd_m1) begin
            spot_reg <= mul_q30(su_rdata, dp_rdata);
        end
        if (cmd.lv_load) begin
            vup_reg <= val_rdata;
        end
        if (cmd.nd_m1) begin
            vdn_reg    <= val_rdata;
            prod_u_reg <= 63'(p_reg) * 63'(vup_reg);
            prod_d_reg <= 63'(q_reg) * 63'(val_rdata);
        end
        if (cmd.nd_m2) begin
            mix_reg <= mix_sum[61:30];
        end
        if (cmd.nd_m3) begin
            cont_reg <= mul_q30(mix_reg, FACTOR_W'(df_reg));
        end
        if (cmd.nd_wr) begin
            // lower child of this node is the upper child of the next one
            vup_reg <= vdn_reg;
            res_reg <= v_final;
        end
    end

    assign result = res_reg;

    bop_ram #(.WIDTH(PRICE_W), .DEPTH(DEPTH)) u_spot_up (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (wr_addr),
        .wdata (su_wdata),
        .raddr (su_raddr),
        .rdata (su_rdata)
    );

    bop_ram #(.WIDTH(PRICE_W), .DEPTH(DEPTH)) u_down_pow (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (wr_addr),
        .wdata (dp_wdata),
        .raddr (dp_raddr),
        .rdata (dp_rdata)
    );

    bop_ram #(.WIDTH(PRICE_W), .DEPTH(DEPTH)) u_node_val (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

endmodule

[sv/binomial_option_pricer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_option_pricer
// CRR binomial lattice pricer: one option problem in, root price out.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   input    | s_valid / s_ready   | spot, strike, is_put, american, factors
//   result   | m_valid / m_ready   | m_price
//   config   | cfg_wr_en           | cfg_wr_data (num_steps)
//
// Run time grows with N = clamped num_steps: it is set by the node update
// (read, products, mix, discount, write; one read port per table) over the
// N(N+1)/2 interior nodes.
// One item in flight; s_ready is high only while the sequencer is idle,
// which it re-enters in the cycle after each hand-off.
// The root price sits in the output register until taken; a stalled
// result holds the sequencer in its hand-off state.
// Reset is synchronous, active low; num_steps resets to 256. No memory clear.
// ----------------------------------------------------------------------------
module binomial_option_pricer #(
    parameter int MAX_STEPS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bop_pkg::NUM_STEPS_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bop_pkg::PRICE_W-1:0]     s_spot,
    input  logic [bop_pkg::PRICE_W-1:0]     s_strike,
    input  logic                            s_is_put,
    input  logic                            s_american,
    input  logic [bop_pkg::FACTOR_W-1:0]    s_up_factor,
    input  logic [bop_pkg::FRAC_W-1:0]      s_down_factor,
    input  logic [bop_pkg::FRAC_W-1:0]      s_up_prob,
    input  logic [bop_pkg::FRAC_W-1:0]      s_discount,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bop_pkg::PRICE_W-1:0]     m_price
);
    import bop_pkg::*;

    localparam int AW = $clog2(MAX_STEPS + 1);

    logic [NUM_STEPS_W-1:0] num_steps_reg;
    logic                   m_valid_reg;
    logic [PRICE_W-1:0]     m_price_reg;
    logic                   out_free, out_load;
    bop_cmd_t               cmd;
    logic [AW-1:0]          su_raddr, dp_raddr, val_raddr, wr_addr;
    logic [PRICE_W-1:0]     result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_steps_reg <= NUM_STEPS_RST;
        end else if (cfg_wr_en) begin
            num_steps_reg <= cfg_wr_data;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_price_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_price = m_price_reg;

    bop_ctrl #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .num_steps (num_steps_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_free  (out_free),
        .out_load  (out_load),
        .cmd       (cmd),
        .su_raddr  (su_raddr),
        .dp_raddr  (dp_raddr),
        .val_raddr (val_raddr),
        .wr_addr   (wr_addr)
    );

    bop_dp #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .su_raddr    (su_raddr),
        .dp_raddr    (dp_raddr),
        .val_raddr   (val_raddr),
        .wr_addr     (wr_addr),
        .spot        (s_spot),
        .strike      (s_strike),
        .is_put      (s_is_put),
        .american    (s_american),
        .up_factor   (s_up_factor),
        .down_factor (s_down_factor),
        .up_prob     (s_up_prob),
        .discount    (s_discount),
        .result      (result)
    );

    // one problem at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a problem is in flight");

    // a new result never overwrites one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("result beat not presented after load");

endmodule
